// ----- sv/tlik_pkg.sv -----
// Shared widths, register indexes, pipeline depths and CORDIC constants for the arm IK block.
package tlik_pkg;

  localparam int LEN_W = 20;   // link length, unsigned Q4.16
  localparam int XY_W  = 32;   // target coordinate, signed Q16.16
  localparam int ANG_W = 32;   // joint angle, signed Q16.16
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SECOND_LINK = 2'd1;
  localparam logic [LEN_W-1:0] LEN_RESET       = 20'd16384;

  localparam int SQ_W  = 64;   // r^2 in Q32.32
  localparam int DEN_W = 42;   // 2*l1*l2
  localparam int REM_W = 58;   // |num| << 16
  localparam int Q_W   = 17;   // quotient, at most 1.0 in Q1.16
  localparam int C_W   = 18;   // signed cosine
  localparam int V_W   = 33;   // 1 - c^2 in Q1.32
  localparam int S_W   = 17;   // sine

  localparam logic [Q_W-1:0]        Q_ONE = 17'd65536;
  localparam logic signed [C_W-1:0] C_ONE = 18'sd65536;
  localparam logic [V_W-1:0]        V_ONE = 33'h1_0000_0000;

  localparam int CRD_IN_W     = 44;
  localparam int CRD_W        = 46;
  localparam int Z_W          = 35;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [Z_W-1:0] Q30_PI = 35'sd3373259426;

  localparam int DIV_STAGES  = 17;
  localparam int SQRT_STAGES = 17;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 4;
  localparam int PIPE_DEPTH  = 4 + DIV_STAGES + 3 + SQRT_STAGES + 2 + CORDIC_LAT + 1;

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    case (i)
      0:  return 35'sd843314857;
      1:  return 35'sd497837829;
      2:  return 35'sd263043837;
      3:  return 35'sd133525159;
      4:  return 35'sd67021687;
      5:  return 35'sd33543516;
      6:  return 35'sd16775851;
      7:  return 35'sd8388437;
      8:  return 35'sd4194283;
      9:  return 35'sd2097141;
      10: return 35'sd1048576;
      11: return 35'sd524288;
      12: return 35'sd262144;
      13: return 35'sd131072;
      14: return 35'sd65536;
      15: return 35'sd32768;
      16: return 35'sd16384;
      17: return 35'sd8192;
      18: return 35'sd4096;
      19: return 35'sd2048;
      20: return 35'sd1024;
      21: return 35'sd512;
      22: return 35'sd256;
      23: return 35'sd128;
      24: return 35'sd64;
      25: return 35'sd32;
      26: return 35'sd16;
      27: return 35'sd8;
      28: return 35'sd4;
      29: return 35'sd2;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- sv/tlik_div.sv -----
// Pipelined restoring divider: one quotient bit per stage against a fixed divisor.
module tlik_div import tlik_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  logic [REM_W-1:0] rem_in,
  output logic [Q_W-1:0]   q_out
);

  logic [REM_W-1:0] rem_r [DIV_STAGES];
  logic [Q_W-1:0]   q_r   [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - j;
    logic [REM_W-1:0] rem_src;
    logic [Q_W-1:0]   q_src;
    logic [REM_W-1:0] dsh;

    if (j == 0) begin : g_first
      assign rem_src = rem_in;
      assign q_src   = '0;
    end else begin : g_next
      assign rem_src = rem_r[j-1];
      assign q_src   = q_r[j-1];
    end

    assign dsh = REM_W'(den) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_src >= dsh) begin
          rem_r[j] <= rem_src - dsh;
          q_r[j]   <= {q_src[Q_W-2:0], 1'b1};
        end else begin
          rem_r[j] <= rem_src;
          q_r[j]   <= {q_src[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign q_out = q_r[DIV_STAGES-1];

endmodule

// ----- sv/tlik_sqrt.sv -----
// Pipelined integer square root: one root bit per stage, floor result.
module tlik_sqrt import tlik_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [V_W-1:0] v_in,
  output logic [S_W-1:0] root_out
);

  localparam int T_W = V_W + 3;

  logic [V_W-1:0] rem_r  [SQRT_STAGES];
  logic [S_W-1:0] root_r [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int K = SQRT_STAGES - 1 - j;
    logic [V_W-1:0] rem_src;
    logic [S_W-1:0] root_src;
    logic [T_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_src  = v_in;
      assign root_src = '0;
    end else begin : g_next
      assign rem_src  = rem_r[j-1];
      assign root_src = root_r[j-1];
    end

    // (root + 2^k)^2 - root^2
    assign trial = (T_W'(root_src) << (K + 1)) + (T_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        if (T_W'(rem_src) >= trial) begin
          rem_r[j]  <= rem_src - trial[V_W-1:0];
          root_r[j] <= root_src | (S_W'(1) << K);
        end else begin
          rem_r[j]  <= rem_src;
          root_r[j] <= root_src;
        end
      end
    end
  end

  assign root_out = root_r[SQRT_STAGES-1];

endmodule

// ----- sv/tlik_cordic.sv -----
// Pipelined vectoring CORDIC atan2 with half-plane fold and leading-zero normalize.
module tlik_cordic import tlik_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [CRD_IN_W-1:0] y_in,
  input  logic signed [CRD_IN_W-1:0] x_in,
  output logic signed [ANG_W-1:0]    angle
);

  // fold into right half plane
  logic signed [CRD_IN_W-1:0] x_f, y_f, ay_f;
  logic signed [Z_W-1:0]      z_f;
  logic [CRD_IN_W-1:0]        m_f;
  logic                       neg_x;

  always_comb begin
    neg_x = x_in[CRD_IN_W-1];
    x_f   = neg_x ? -x_in : x_in;
    y_f   = neg_x ? -y_in : y_in;
    z_f   = neg_x ? (y_in[CRD_IN_W-1] ? -Q30_PI : Q30_PI) : '0;
    ay_f  = y_f[CRD_IN_W-1] ? -y_f : y_f;
    m_f   = x_f | ay_f;
  end

  logic signed [CRD_IN_W-1:0] x_p, y_p, x_a, y_a, x_b, y_b;
  logic signed [Z_W-1:0]      z_p, z_a, z_b;
  logic [CRD_IN_W-1:0]        m_p, m_a;
  logic                       zero_p, zero_a, zero_b;

  always_ff @(posedge clk) begin
    if (en) begin
      x_p    <= x_f;
      y_p    <= y_f;
      z_p    <= z_f;
      m_p    <= m_f;
      zero_p <= (x_in == '0) && (y_in == '0);
    end
  end

  // normalize, coarse steps
  logic signed [CRD_IN_W-1:0] x_n1, y_n1;
  logic [CRD_IN_W-1:0]        m_n1;
  always_comb begin
    x_n1 = x_p;
    y_n1 = y_p;
    m_n1 = m_p;
    if (m_n1 < (CRD_IN_W'(1) << 8)) begin
      x_n1 = x_n1 <<< 32; y_n1 = y_n1 <<< 32; m_n1 = m_n1 << 32;
    end
    if (m_n1 < (CRD_IN_W'(1) << 24)) begin
      x_n1 = x_n1 <<< 16; y_n1 = y_n1 <<< 16; m_n1 = m_n1 << 16;
    end
    if (m_n1 < (CRD_IN_W'(1) << 32)) begin
      x_n1 = x_n1 <<< 8; y_n1 = y_n1 <<< 8; m_n1 = m_n1 << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a    <= x_n1;
      y_a    <= y_n1;
      z_a    <= z_p;
      m_a    <= m_n1;
      zero_a <= zero_p;
    end
  end

  // normalize, fine steps
  logic signed [CRD_IN_W-1:0] x_n2, y_n2;
  logic [CRD_IN_W-1:0]        m_n2;
  always_comb begin
    x_n2 = x_a;
    y_n2 = y_a;
    m_n2 = m_a;
    if (m_n2 < (CRD_IN_W'(1) << 36)) begin
      x_n2 = x_n2 <<< 4; y_n2 = y_n2 <<< 4; m_n2 = m_n2 << 4;
    end
    if (m_n2 < (CRD_IN_W'(1) << 38)) begin
      x_n2 = x_n2 <<< 2; y_n2 = y_n2 <<< 2; m_n2 = m_n2 << 2;
    end
    if (m_n2 < (CRD_IN_W'(1) << 39)) begin
      x_n2 = x_n2 <<< 1; y_n2 = y_n2 <<< 1; m_n2 = m_n2 << 1;
    end
    if (m_n2 < (CRD_IN_W'(1) << 40)) begin
      x_n2 = x_n2 <<< 1; y_n2 = y_n2 <<< 1; m_n2 = m_n2 << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_b    <= x_n2;
      y_b    <= y_n2;
      z_b    <= z_a;
      zero_b <= zero_a;
    end
  end

  // micro-rotations
  logic signed [CRD_W-1:0] x_r [CORDIC_STEPS];
  logic signed [CRD_W-1:0] y_r [CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_r [CORDIC_STEPS];
  logic                    zero_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CRD_W-1:0] x_s, y_s, xs, ys;
    logic signed [Z_W-1:0]   z_s;
    logic                    zero_s;

    if (i == 0) begin : g_first
      assign x_s    = CRD_W'(x_b);
      assign y_s    = CRD_W'(y_b);
      assign z_s    = z_b;
      assign zero_s = zero_b;
    end else begin : g_next
      assign x_s    = x_r[i-1];
      assign y_s    = y_r[i-1];
      assign z_s    = z_r[i-1];
      assign zero_s = zero_r[i-1];
    end

    assign xs = x_s >>> i;
    assign ys = y_s >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i] <= zero_s;
        if (!y_s[CRD_W-1]) begin
          x_r[i] <= x_s + ys;
          y_r[i] <= y_s - xs;
          z_r[i] <= z_s + atan_q30(i);
        end else begin
          x_r[i] <= x_s - ys;
          y_r[i] <= y_s + xs;
          z_r[i] <= z_s - atan_q30(i);
        end
      end
    end
  end

  // round Q5.30 to Q16.16
  logic signed [Z_W-1:0] z_rnd;
  assign z_rnd = (z_r[CORDIC_STEPS-1] + Z_W'(8192)) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zero_r[CORDIC_STEPS-1] ? '0 : ANG_W'(z_rnd);
    end
  end

endmodule

// ----- sv/two_link_inverse_kinematics.sv -----
// Top level: pipelined inverse kinematics for a two-link planar arm.
//
// Input channel: in_valid/in_ready with target_x, target_y (signed Q16.16 m).
// Output channel: out_valid/out_ready with shoulder_angle, elbow_angle
// (signed Q16.16 rad) and reach_status (1 = target outside the workspace,
// angles then zero). The elbow always takes the negative branch.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is the first link length, index 1 the second, others are dropped.
// cfg_ready is always high; derived link products are registered from the
// link registers and settle well before any new target reaches them.
//
// One target per cycle is accepted while the receiver keeps taking
// results. The depth is set by the 17-stage divider for the elbow
// cosine, the 17-stage square root for its sine and the 34-stage CORDIC.
// The whole pipeline advances together: when the output holds a result the
// receiver has not taken, every stage holds and in_ready drops. Reset
// clears all valid bits, holds in_ready low and sets both links to 0.25 m.
module two_link_inverse_kinematics import tlik_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [XY_W-1:0]  target_x,
  input  logic signed [XY_W-1:0]  target_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANG_W-1:0] shoulder_angle,
  output logic signed [ANG_W-1:0] elbow_angle,
  output logic                    reach_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [LEN_W-1:0]        cfg_data
);

  typedef struct packed {
    logic                   unr;
    logic                   neg;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } div_sb_t;

  typedef struct packed {
    logic signed [C_W-1:0]  c;
    logic                   unr;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } sqrt_sb_t;

  // ---------------------------------------------------------------- config
  logic [LEN_W-1:0] first_link_length, second_link_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_link_length  <= LEN_RESET;
      second_link_length <= LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_LINK:  first_link_length  <= cfg_data;
        REG_SECOND_LINK: second_link_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Link products, recomputed every cycle from the registers.
  logic [2*LEN_W-1:0]   l1sq, l2sq, lo;
  logic [LEN_W:0]       lsum;
  logic [LEN_W-1:0]     ldiff;
  logic [DEN_W-1:0]     den;
  logic [2*LEN_W+1:0]   hi;
  logic [2*LEN_W:0]     sumsq;

  always_ff @(posedge clk) begin
    l1sq  <= first_link_length * first_link_length;
    l2sq  <= second_link_length * second_link_length;
    lsum  <= {1'b0, first_link_length} + {1'b0, second_link_length};
    ldiff <= (first_link_length > second_link_length) ?
             first_link_length - second_link_length :
             second_link_length - first_link_length;
    den   <= {(2*LEN_W)'(first_link_length * second_link_length), 1'b0};
    lo    <= ldiff * ldiff;
    hi    <= lsum * lsum;
    sumsq <= {1'b0, l1sq} + {1'b0, l2sq};
  end

  // ---------------------------------------------------------------- control
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;

  // Advance everything unless the output holds an untaken transfer.
  assign adv       = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = adv && !rst;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- r^2
  logic [XY_W-1:0]        ux, uy;
  logic [SQ_W-1:0]        sqx1, sqy1, r2_2;
  logic signed [XY_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic                   unr3, unr4, neg4;
  logic signed [DEN_W:0]  num3;
  logic [DEN_W-1:0]       mag4;

  assign ux = target_x[XY_W-1] ? (~target_x + 1'b1) : target_x;
  assign uy = target_y[XY_W-1] ? (~target_y + 1'b1) : target_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      // square both coordinates
      sqx1 <= ux * ux;
      sqy1 <= uy * uy;
      x1   <= target_x;
      y1   <= target_y;
      // sum to r^2
      r2_2 <= sqx1 + sqy1;
      x2   <= x1;
      y2   <= y1;
      // workspace test and cosine numerator; the numerator only
      // matters for reachable targets, where it fits easily
      unr3 <= (r2_2 < SQ_W'(lo)) || (r2_2 > SQ_W'(hi));
      num3 <= $signed(r2_2[DEN_W:0] - (DEN_W+1)'(sumsq));
      x3   <= x2;
      y3   <= y2;
      // split into sign and magnitude for the divider
      neg4 <= num3[DEN_W];
      mag4 <= DEN_W'(num3[DEN_W] ? -num3 : num3);
      unr4 <= unr3;
      x4   <= x3;
      y4   <= y3;
    end
  end

  // ---------------------------------------------------------------- divide
  logic [Q_W-1:0] q_div;
  div_sb_t        div_sb [DIV_STAGES];

  tlik_div u_div (
    .clk    (clk),
    .en     (adv),
    .den    (den),
    .rem_in ({mag4, 16'b0}),
    .q_out  (q_div)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      div_sb[0] <= '{unr: unr4, neg: neg4, x: x4, y: y4};
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_sb[i] <= div_sb[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- cosine, 1 - c^2
  logic [Q_W-1:0]            qc;
  logic signed [C_W-1:0]     c_next;
  logic signed [C_W-1:0]     c5, c6, c7;
  logic signed [2*C_W-1:0]   csq_full;
  logic [V_W-1:0]            csq6, v7;
  logic                      unr5, unr6, unr7;
  logic signed [XY_W-1:0]    x5, y5, x6, y6, x7, y7;

  assign qc = (q_div > Q_ONE) ? Q_ONE : q_div;

  always_comb begin
    if (den == '0) begin
      c_next = C_ONE;   // zero link: treat the elbow as straight
    end else if (div_sb[DIV_STAGES-1].neg) begin
      c_next = -$signed({1'b0, qc});
    end else begin
      c_next = $signed({1'b0, qc});
    end
  end

  assign csq_full = c5 * c5;

  always_ff @(posedge clk) begin
    if (adv) begin
      c5   <= c_next;
      unr5 <= div_sb[DIV_STAGES-1].unr;
      x5   <= div_sb[DIV_STAGES-1].x;
      y5   <= div_sb[DIV_STAGES-1].y;
      csq6 <= csq_full[V_W-1:0];
      c6   <= c5;
      unr6 <= unr5;
      x6   <= x5;
      y6   <= y5;
      v7   <= V_ONE - csq6;
      c7   <= c6;
      unr7 <= unr6;
      x7   <= x6;
      y7   <= y6;
    end
  end

  // ---------------------------------------------------------------- sine
  logic [S_W-1:0] s_root;
  sqrt_sb_t       sqrt_sb [SQRT_STAGES];

  tlik_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .v_in     (v7),
    .root_out (s_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sqrt_sb[0] <= '{c: c7, unr: unr7, x: x7, y: y7};
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sqrt_sb[i] <= sqrt_sb[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- correction vector
  logic [LEN_W+S_W-1:0]           l2s_full, l2s8;
  logic signed [LEN_W+C_W:0]      l2c_full, l2c8;
  logic [S_W-1:0]                 s8, s9;
  logic signed [C_W-1:0]          c8, c9;
  logic                           unr8, unr9;
  logic signed [XY_W-1:0]         x8, y8, x9, y9;
  logic signed [CRD_IN_W-1:0]     bx9, by9;

  assign l2s_full = second_link_length * s_root;
  assign l2c_full = $signed({1'b0, second_link_length}) * sqrt_sb[SQRT_STAGES-1].c;

  always_ff @(posedge clk) begin
    if (adv) begin
      l2s8 <= l2s_full;
      l2c8 <= l2c_full;
      s8   <= s_root;
      c8   <= sqrt_sb[SQRT_STAGES-1].c;
      unr8 <= sqrt_sb[SQRT_STAGES-1].unr;
      x8   <= sqrt_sb[SQRT_STAGES-1].x;
      y8   <= sqrt_sb[SQRT_STAGES-1].y;
      // beta = atan2(-l2*s, l1 + l2*c), all in Q12.32
      bx9  <= $signed({8'b0, first_link_length, 16'b0}) + CRD_IN_W'(l2c8);
      by9  <= -$signed({7'b0, l2s8});
      s9   <= s8;
      c9   <= c8;
      unr9 <= unr8;
      x9   <= x8;
      y9   <= y8;
    end
  end

  // ---------------------------------------------------------------- three atan2 units
  logic signed [ANG_W-1:0] ang_elbow, ang_gamma, ang_beta;
  logic                    crd_unr [CORDIC_LAT];

  tlik_cordic u_cordic_elbow (
    .clk   (clk),
    .en    (adv),
    .y_in  ($signed({27'b0, s9})),
    .x_in  (CRD_IN_W'(c9)),
    .angle (ang_elbow)
  );

  tlik_cordic u_cordic_gamma (
    .clk   (clk),
    .en    (adv),
    .y_in  (CRD_IN_W'(y9)),
    .x_in  (CRD_IN_W'(x9)),
    .angle (ang_gamma)
  );

  tlik_cordic u_cordic_beta (
    .clk   (clk),
    .en    (adv),
    .y_in  (by9),
    .x_in  (bx9),
    .angle (ang_beta)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      crd_unr[0] <= unr9;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        crd_unr[i] <= crd_unr[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  // Zero both angles for targets outside the annulus.
  always_ff @(posedge clk) begin
    if (adv) begin
      reach_status   <= crd_unr[CORDIC_LAT-1];
      shoulder_angle <= crd_unr[CORDIC_LAT-1] ? '0 : ang_gamma - ang_beta;
      elbow_angle    <= crd_unr[CORDIC_LAT-1] ? '0 : -ang_elbow;
    end
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the two-link arm inverse kinematics block.
`timescale 1ns / 1ps

module tb;
  import tlik_pkg::*;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint NORM_LO = 64'sd1 << 40;
  localparam int     LIMIT   = 2000000;
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic signed [ANG_W-1:0] shoulder;
    logic signed [ANG_W-1:0] elbow;
    logic                    unreachable;
  } ik_sol_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [XY_W-1:0] target_x = '0;
  logic signed [XY_W-1:0] target_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ANG_W-1:0] shoulder_angle;
  logic signed [ANG_W-1:0] elbow_angle;
  logic reach_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;

  // Predictor copy of the link registers.
  logic [LEN_W-1:0] link1_len = LEN_RESET;
  logic [LEN_W-1:0] link2_len = LEN_RESET;

  ik_sol_t pending_solutions[$];
  int     mismatches = 0;
  int     solved_cnt = 0;
  int     unreach_cnt = 0;
  int     cycle_cnt = 0;
  bit     stall_long = 1'b0;
  bit     stall_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_link_inverse_kinematics u_dut (.*);

  // Generous watchdog; a correct run ends far earlier.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;  // arithmetic shift already rounds toward minus infinity
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, ax, ay, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    ax = x;
    ay = (y < 0) ? -y : y;
    while ((ax | ay) < NORM_LO) begin
      x = x * 2; y = y * 2; ax = ax * 2; ay = ay * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_q30(i));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_q30(i));
      end
    end
    return floor_shr(z + 8192, 14);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic ik_sol_t solve_arm(logic signed [XY_W-1:0] tx,
                                        logic signed [XY_W-1:0] ty);
    ik_sol_t sol;
    longint x, y, l1, l2, num, c, s, elbow, gamma, beta;
    longint unsigned ux, uy, r2, diff, lo, hi, den, mag, q;
    x = tx; y = ty;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    r2 = ux * ux + uy * uy;
    l1 = link1_len; l2 = link2_len;
    diff = (l1 > l2) ? l1 - l2 : l2 - l1;
    lo = diff * diff;
    hi = (l1 + l2) * (l1 + l2);
    den = 2 * l1 * l2;
    sol = '0;
    if (r2 < lo || r2 > hi) begin
      sol.unreachable = 1'b1;
      return sol;
    end
    if (den == 0) begin
      c = 65536;
    end else begin
      num = longint'(r2) - l1 * l1 - l2 * l2;
      mag = (num < 0) ? -num : num;
      q = (mag << 16) / den;
      if (q > 65536) q = 65536;
      c = (num < 0) ? -longint'(q) : longint'(q);
    end
    s = root_floor(64'h1_0000_0000 - longint'(c * c));
    elbow = -cordic_angle(s, c);
    gamma = cordic_angle(y, x);
    beta = cordic_angle(-(l2 * s), (l1 << 16) + l2 * c);
    sol.shoulder = ANG_W'(gamma - beta);
    sol.elbow = ANG_W'(elbow);
    return sol;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_target(logic signed [XY_W-1:0] tx, logic signed [XY_W-1:0] ty);
    in_valid <= 1'b1;
    target_x <= tx;
    target_y <= ty;
    pending_solutions.push_back(solve_arm(tx, ty));
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid only when the next item is not sent back to back.
  task automatic idle_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_link(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FIRST_LINK) link1_len = len;
    else if (idx == REG_SECOND_LINK) link2_len = len;
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [XY_W-1:0] rand_coord(int unsigned reach);
    int unsigned mag;
    mag = $urandom_range(reach, 0);
    return ($urandom_range(1, 0) == 1) ? -XY_W'(mag) : XY_W'(mag);
  endfunction

  // Per-axis sample: points mostly inside the annulus for the current links.
  task automatic random_burst(int n_items);
    int unsigned reach, gap;
    int left;
    left = n_items;
    reach = link1_len + link2_len;
    while (left > 0) begin
      for (int b = $urandom_range(12, 1); b > 0 && left > 0; b--) begin
        case ($urandom_range(9, 0))
          0: send_target($urandom, $urandom);
          1: send_target(rand_coord(reach + reach / 4), rand_coord(reach + reach / 4));
          default: send_target(rand_coord(reach * 7 / 10), rand_coord(reach * 7 / 10));
        endcase
        left--;
      end
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) idle_sender(gap);
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed_reset_links();
    send_target(32'sd0, 32'sd0);              // origin, equal links: null vectors
    send_target(32'sd32768, 32'sd0);          // full reach along +x
    send_target(-32'sd32768, 32'sd0);         // full reach along -x
    send_target(32'sd0, -32'sd32768);
    send_target(32'sd16384, 32'sd16384);
    send_target(-32'sd16384, -32'sd1);        // x negative, y negative: pre-rotation
    send_target(-32'sd20000, 32'sd0);         // x negative, y zero
    send_target(32'sd32769, 32'sd0);          // just beyond reach
    send_target(32'h7fffffff, 32'h7fffffff);  // field extremes
    send_target(32'h80000000, 32'h80000000);
    send_target(32'h80000000, 32'h7fffffff);
    send_target(32'sd1, -32'sd1);
    idle_sender(1);
    wait_drained();
  endtask

  task automatic test_link_extremes();
    write_link(REG_FIRST_LINK, 20'hFFFFF);
    write_link(REG_SECOND_LINK, 20'd1);
    send_target(32'sd1048575, 32'sd0);        // inside the annulus, between its edges
    send_target(32'sd1048576, 32'sd0);        // outer edge
    send_target(32'sd0, -32'sd1048576);
    send_target(32'sd1048573, 32'sd0);        // inside the hole
    send_target(-32'sd700000, 32'sd741455);
    wait_drained();
    write_link(REG_SECOND_LINK, 20'hFFFFF);
    send_target(32'sd0, 32'sd0);
    send_target(32'sd2097150, 32'sd0);
    send_target(-32'sd1482910, -32'sd1482910);
    wait_drained();
    // Zero link: cosine forced to one.
    write_link(REG_FIRST_LINK, 20'd0);
    send_target(32'sd0, 32'sd1048575);
    send_target(-32'sd1048575, 32'sd0);
    wait_drained();
    write_link(REG_UNMAPPED, 20'd12345);      // unmapped index, ignored
    send_target(32'sd1048575, 32'sd0);
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      write_link(REG_FIRST_LINK, 20'($urandom_range(20'hFFFFF, 1)));
      write_link(REG_SECOND_LINK, (ph == 0) ? link1_len : 20'($urandom_range(20'hFFFFF, 1)));
      random_burst(180);
      wait_drained();
    end
    write_link(REG_FIRST_LINK, LEN_RESET);
    write_link(REG_SECOND_LINK, 20'd8192);
  endtask

  // Long receiver hold-off while the sender keeps offering, so the pipe fills.
  task automatic test_backpressure();
    stall_long = 1'b1;
    random_burst(150);
    stall_long = 1'b0;
    wait_drained();
    random_burst(120);
    wait_drained();
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_long) begin
      out_ready <= 1'b0;
    end else if ($urandom_range(63, 0) == 0) begin
      stall_on <= ~stall_on;
      out_ready <= stall_on;
    end else begin
      out_ready <= stall_on ? ($urandom_range(3, 0) == 0) : 1'b1;
    end
  end

  // The long hold-off counts its own cycles, then releases.
  initial begin
    wait (stall_long);
    repeat (400) @(posedge clk);
    stall_long = 1'b0;
  end

  // Compare each transfer against the oldest prediction.
  always @(posedge clk) begin
    ik_sol_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_solutions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        want = pending_solutions.pop_front();
        if (want.unreachable) unreach_cnt++;
        else solved_cnt++;
        if (shoulder_angle !== want.shoulder || elbow_angle !== want.elbow ||
            reach_status !== want.unreachable) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sh=%0d el=%0d st=%0b got sh=%0d el=%0d st=%0b",
                     want.shoulder, want.elbow, want.unreachable,
                     shoulder_angle, elbow_angle, reach_status);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_reset_links();
    test_link_extremes();
    test_random_settings();
    test_backpressure();
    wait_drained();
    $display("covered %0d solved and %0d unreachable targets", solved_cnt, unreach_cnt);
    $display("across reset, extreme, zero and random link lengths with long output stalls");
    if (mismatches == 0 && pending_solutions.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
